/* rtl/rrwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rrwc_pkg;

   // Fixed geometry
   localparam int LOG_REGS   = 32;
   localparam int PHYS_REGS  = 128;
   localparam int BR_SLOTS   = 16;
   localparam int LIST_DEPTH = 64;
   localparam int FREE_SIZE  = PHYS_REGS - LOG_REGS;

   localparam int LR_W  = 5;
   localparam int PR_W  = 7;
   localparam int LI_W  = 6;
   localparam int FR_W  = 7;
   localparam int TAG_W = 4;
   localparam int CNT_W = 7;
   localparam int EI_W  = 23;
   localparam int SM_W  = TAG_W + LR_W;
   localparam int SEQ_W = 6;

   // Action codes
   localparam logic [4:0] ACT_STALL_REGS   = 5'd0;
   localparam logic [4:0] ACT_STALL_BRANCH = 5'd1;
   localparam logic [4:0] ACT_GET_MASK     = 5'd2;
   localparam logic [4:0] ACT_RENAME_SRC   = 5'd3;
   localparam logic [4:0] ACT_RENAME_DST   = 5'd4;
   localparam logic [4:0] ACT_CHECKPOINT   = 5'd5;
   localparam logic [4:0] ACT_STALL_DISP   = 5'd6;
   localparam logic [4:0] ACT_DISPATCH     = 5'd7;
   localparam logic [4:0] ACT_IS_READY     = 5'd8;
   localparam logic [4:0] ACT_CLEAR_READY  = 5'd9;
   localparam logic [4:0] ACT_SET_READY    = 5'd10;
   localparam logic [4:0] ACT_READ         = 5'd11;
   localparam logic [4:0] ACT_WRITE        = 5'd12;
   localparam logic [4:0] ACT_COMPLETE     = 5'd13;
   localparam logic [4:0] ACT_RESOLVE      = 5'd14;
   localparam logic [4:0] ACT_PEEK_HEAD    = 5'd15;
   localparam logic [4:0] ACT_COMMIT       = 5'd16;
   localparam logic [4:0] ACT_SQUASH       = 5'd17;
   localparam logic [4:0] ACT_SET_EXC      = 5'd18;
   localparam logic [4:0] ACT_SET_LDVIOL   = 5'd19;
   localparam logic [4:0] ACT_SET_BRMISP   = 5'd20;
   localparam logic [4:0] ACT_SET_VALMISP  = 5'd21;
   localparam logic [4:0] ACT_GET_EXC      = 5'd22;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic exec_go;
      logic ckpt_step;
      logic restore_step;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_ckpt;
      logic need_restore;
      logic ckpt_last;
      logic restore_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/register_renamer_with_checkpoints_core.sv */
// A word is captured when accepted, executes once the output register is free, and
// its result is registered when it executes; no new word is accepted until idle.
// A checkpoint copies the rename map one entry a cycle into the shadow memory;
// a mispredicted resolve restores it through the registered shadow memory read.
// Reset (synchronous): maps identity, rings empty of used entries, no live branches.
`timescale 1ns / 1ps
`default_nettype none

module register_renamer_with_checkpoints_core
   import rrwc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [4:0]        req_action,
   input  wire logic [LR_W-1:0]   req_log_reg,
   input  wire logic [PR_W-1:0]   req_phys_reg,
   input  wire logic [63:0]       req_write_value,
   input  wire logic [LI_W-1:0]   req_entry_index,
   input  wire logic [TAG_W-1:0]  req_branch_tag,
   input  wire logic [CNT_W-1:0]  req_bundle_count,
   input  wire logic              req_predicted_right,
   input  wire logic              req_has_dest,
   input  wire logic [4:0]        req_inst_kind,
   input  wire logic [63:0]       req_inst_pc,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_stall_res,
   output logic [PR_W-1:0]        rsp_phys_out,
   output logic [LI_W-1:0]        rsp_index_out,
   output logic [63:0]            rsp_read_data,
   output logic                   rsp_bit_out,
   output logic                   rsp_head_valid,
   output logic [4:0]             rsp_head_status,
   output logic [4:0]             rsp_head_kind,
   output logic [63:0]            rsp_head_pc,
   output logic [BR_SLOTS-1:0]    rsp_branch_mask
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   rrwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rrwc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_log_reg         (req_log_reg),
      .req_phys_reg        (req_phys_reg),
      .req_write_value     (req_write_value),
      .req_entry_index     (req_entry_index),
      .req_branch_tag      (req_branch_tag),
      .req_bundle_count    (req_bundle_count),
      .req_predicted_right (req_predicted_right),
      .req_has_dest        (req_has_dest),
      .req_inst_kind       (req_inst_kind),
      .req_inst_pc         (req_inst_pc),
      .rsp_stall_res       (rsp_stall_res),
      .rsp_phys_out        (rsp_phys_out),
      .rsp_index_out       (rsp_index_out),
      .rsp_read_data       (rsp_read_data),
      .rsp_bit_out         (rsp_bit_out),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_status     (rsp_head_status),
      .rsp_head_kind       (rsp_head_kind),
      .rsp_head_pc         (rsp_head_pc),
      .rsp_branch_mask     (rsp_branch_mask)
   );

endmodule

`default_nettype wire

/* rtl/rrwc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrwc_ctrl
   import rrwc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_EXEC    = 4'b0010,
      ST_CKPT    = 4'b0100,
      ST_RESTORE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in          = state_ff;
      cmd.capture       = 1'b0;
      cmd.exec_go       = 1'b0;
      cmd.ckpt_step     = 1'b0;
      cmd.restore_step  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.exec_go = 1'b1;
               if (status.need_ckpt)         state_in = ST_CKPT;
               else if (status.need_restore) state_in = ST_RESTORE;
               else                          state_in = ST_IDLE;
            end
         end
         ST_CKPT: begin
            cmd.ckpt_step = 1'b1;
            if (status.ckpt_last) state_in = ST_IDLE;
         end
         ST_RESTORE: begin
            cmd.restore_step = 1'b1;
            if (status.restore_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output word valid
   always_comb begin
      if (cmd.exec_go)    rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_EXEC)
      else $error("accepted word did not enter execute");

   a_exec_gives_word: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_go |=> rsp_valid_ff)
      else $error("executed word produced no result");

   a_exec_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !out_free) |=> state_ff == ST_EXEC)
      else $error("execute left while output blocked");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CKPT || state_ff == ST_RESTORE) |-> req_stall)
      else $error("input open during map copy");

endmodule

`default_nettype wire

/* rtl/rrwc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrwc_datapath
   import rrwc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_cmd_type       cmd,
   output dp_status_type          status,
   input  wire logic [4:0]        req_action,
   input  wire logic [LR_W-1:0]   req_log_reg,
   input  wire logic [PR_W-1:0]   req_phys_reg,
   input  wire logic [63:0]       req_write_value,
   input  wire logic [LI_W-1:0]   req_entry_index,
   input  wire logic [TAG_W-1:0]  req_branch_tag,
   input  wire logic [CNT_W-1:0]  req_bundle_count,
   input  wire logic              req_predicted_right,
   input  wire logic              req_has_dest,
   input  wire logic [4:0]        req_inst_kind,
   input  wire logic [63:0]       req_inst_pc,
   output logic                   rsp_stall_res,
   output logic [PR_W-1:0]        rsp_phys_out,
   output logic [LI_W-1:0]        rsp_index_out,
   output logic [63:0]            rsp_read_data,
   output logic                   rsp_bit_out,
   output logic                   rsp_head_valid,
   output logic [4:0]             rsp_head_status,
   output logic [4:0]             rsp_head_kind,
   output logic [63:0]            rsp_head_pc,
   output logic [BR_SLOTS-1:0]    rsp_branch_mask
);

   // captured word
   logic [4:0]       act_ff;
   logic [LR_W-1:0]  lr_ff;
   logic [PR_W-1:0]  pr_ff;
   logic [63:0]      wv_ff;
   logic [LI_W-1:0]  ei_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             right_ff, dest_ff;
   logic [4:0]       kind_ff;
   logic [63:0]      pc_ff;

   // architectural state
   logic [PR_W-1:0]     rename_map_ff [LOG_REGS];
   logic [PR_W-1:0]     committed_map_ff [LOG_REGS];
   logic                ready_ff [PHYS_REGS];
   logic                rv_vld_ff [PHYS_REGS];
   logic                fr_vld_ff [FREE_SIZE];
   logic [FR_W-1:0]     free_head_ff, free_tail_ff, free_head_in, free_tail_in;
   logic                fh_phase_ff, ft_phase_ff, fh_phase_in, ft_phase_in;
   logic [LI_W-1:0]     list_head_ff, list_tail_ff, list_head_in, list_tail_in;
   logic                lh_phase_ff, lt_phase_ff, lh_phase_in, lt_phase_in;
   logic [BR_SLOTS-1:0] live_ff, live_in;
   logic [BR_SLOTS-1:0] shadow_mask_ff [BR_SLOTS];
   logic [FR_W:0]       shadow_fh_ff [BR_SLOTS];

   // memories
   logic [63:0]     reg_mem [PHYS_REGS];
   logic [PR_W-1:0] free_mem [FREE_SIZE];
   logic [EI_W-1:0] info_mem [LIST_DEPTH];
   logic [63:0]     pc_mem [LIST_DEPTH];
   logic [PR_W-1:0] shadow_mem [BR_SLOTS*LOG_REGS];

   // registered read data
   logic [63:0]     rv_rd_ff;
   logic            rv_rdv_ff;
   logic [PR_W-1:0] fr_rd_ff;
   logic            fr_rdv_ff;
   logic [EI_W-1:0] info_rd_ff;
   logic [63:0]     pc_rd_ff;
   logic [PR_W-1:0] sm_rd_ff;

   // sweep control
   logic [SEQ_W-1:0] seq_ff;
   logic [TAG_W-1:0] seq_tag_ff, seq_tag_in;
   logic [LR_W-1:0]  seq_idx, rst_idx;

   // execute results and write controls
   logic             r_stall, r_bit, r_hv;
   logic [PR_W-1:0]  r_phys;
   logic [LI_W-1:0]  r_idx;
   logic [63:0]      r_data, r_hpc;
   logic [4:0]       r_hs, r_hk;
   logic             ren_we, rv_we, rdy_we, rdy_val, fr_we, cm_we, info_we, pc_we;
   logic             ckpt_we, squash_cp, clr_shadow;
   logic [LI_W-1:0]  info_waddr;
   logic [EI_W-1:0]  info_wdata;
   logic [LI_W-1:0]  info_raddr;
   logic [PR_W-1:0]  fr_phys;
   logic [LR_W-1:0]  cm_lr;
   logic [BR_SLOTS-1:0] tag_bit;
   logic [8:0]       fc_raw;
   logic [6:0]       fc;
   logic [7:0]       lu_raw;
   logic [6:0]       lu;
   logic [4:0]       zeros;
   logic [TAG_W-1:0] slot;
   logic             slot_ok, head_ok, list_empty;
   logic [LI_W-1:0]  nt;

   assign seq_idx = seq_ff[LR_W-1:0];
   assign rst_idx = LR_W'(seq_ff - SEQ_W'(1));

   // entry read picks the head for peek and commit
   assign info_raddr = (req_action == ACT_PEEK_HEAD || req_action == ACT_COMMIT) ?
                       list_head_ff : req_entry_index;

   // capture and memory reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req_action;
         lr_ff      <= req_log_reg;
         pr_ff      <= req_phys_reg;
         wv_ff      <= req_write_value;
         ei_ff      <= req_entry_index;
         tag_ff     <= req_branch_tag;
         cnt_ff     <= req_bundle_count;
         right_ff   <= req_predicted_right;
         dest_ff    <= req_has_dest;
         kind_ff    <= req_inst_kind;
         pc_ff      <= req_inst_pc;
         rv_rd_ff   <= reg_mem[req_phys_reg];
         rv_rdv_ff  <= rv_vld_ff[req_phys_reg];
         fr_rd_ff   <= free_mem[free_head_ff];
         fr_rdv_ff  <= fr_vld_ff[free_head_ff];
         info_rd_ff <= info_mem[info_raddr];
         pc_rd_ff   <= pc_mem[info_raddr];
      end
      if (cmd.restore_step) begin
         sm_rd_ff <= shadow_mem[{seq_tag_ff, seq_idx}];
      end
   end

   // ring occupancy and branch slot search
   always_comb begin
      fc_raw = {2'b00, free_tail_ff} - {2'b00, free_head_ff};
      if (fh_phase_ff != ft_phase_ff) fc_raw = fc_raw + 9'(FREE_SIZE);
      if (fc_raw[8])                     fc = 7'd0;
      else if (fc_raw > 9'(FREE_SIZE))   fc = 7'(FREE_SIZE);
      else                               fc = fc_raw[6:0];

      lu_raw = {2'b00, list_tail_ff} - {2'b00, list_head_ff};
      if (lh_phase_ff != lt_phase_ff) lu_raw = lu_raw + 8'(LIST_DEPTH);
      if (lu_raw[7])                     lu = 7'd0;
      else if (lu_raw > 8'(LIST_DEPTH))  lu = 7'(LIST_DEPTH);
      else                               lu = lu_raw[6:0];

      zeros = 5'(BR_SLOTS) - 5'($countones(live_ff));

      slot_ok = 1'b0;
      slot    = '0;
      for (int i = BR_SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            slot_ok = 1'b1;
            slot    = TAG_W'(i);
         end
      end
   end

   assign list_empty = (list_head_ff == list_tail_ff) && (lh_phase_ff == lt_phase_ff);
   assign fr_phys    = fr_rdv_ff ? fr_rd_ff : PR_W'(LOG_REGS + int'(free_head_ff));
   assign cm_lr      = info_rd_ff[15:11];
   assign tag_bit    = BR_SLOTS'(1) << tag_ff;
   assign head_ok    = !list_empty && info_rd_ff[0] && (info_rd_ff[2:1] == 2'b00);
   assign nt         = ei_ff + LI_W'(1);

   // execute one action
   always_comb begin
      r_stall = 1'b0; r_phys = '0; r_idx = '0; r_data = '0; r_bit = 1'b0;
      r_hv = 1'b0; r_hs = '0; r_hk = '0; r_hpc = '0;
      ren_we = 1'b0; rv_we = 1'b0; rdy_we = 1'b0; rdy_val = 1'b0;
      fr_we = 1'b0; cm_we = 1'b0; info_we = 1'b0; pc_we = 1'b0;
      ckpt_we = 1'b0; squash_cp = 1'b0; clr_shadow = 1'b0;
      info_waddr = ei_ff; info_wdata = info_rd_ff;
      free_head_in = free_head_ff; free_tail_in = free_tail_ff;
      fh_phase_in = fh_phase_ff; ft_phase_in = ft_phase_ff;
      list_head_in = list_head_ff; list_tail_in = list_tail_ff;
      lh_phase_in = lh_phase_ff; lt_phase_in = lt_phase_ff;
      live_in = live_ff; seq_tag_in = seq_tag_ff;
      case (act_ff)
         ACT_STALL_REGS:   r_stall = {1'b0, cnt_ff} > {1'b0, fc};
         ACT_STALL_BRANCH: r_stall = {2'b00, zeros} < cnt_ff;
         ACT_RENAME_SRC:   r_phys = rename_map_ff[lr_ff];
         ACT_RENAME_DST: begin
            r_phys = fr_phys;
            ren_we = 1'b1;
            if (free_head_ff >= FR_W'(FREE_SIZE - 1)) begin
               free_head_in = '0;
               fh_phase_in  = !fh_phase_ff;
            end else begin
               free_head_in = free_head_ff + FR_W'(1);
            end
         end
         ACT_CHECKPOINT: begin
            if (!slot_ok) begin
               r_stall = 1'b1;
            end else begin
               live_in    = live_ff | (BR_SLOTS'(1) << slot);
               ckpt_we    = 1'b1;
               seq_tag_in = slot;
               r_idx      = LI_W'(slot);
            end
         end
         ACT_STALL_DISP: r_stall = (7'(LIST_DEPTH) - lu) < cnt_ff;
         ACT_DISPATCH: begin
            if (list_head_ff == list_tail_ff && lh_phase_ff != lt_phase_ff) begin
               r_stall = 1'b1;
            end else begin
               r_idx      = list_tail_ff;
               info_we    = 1'b1;
               pc_we      = 1'b1;
               info_waddr = list_tail_ff;
               info_wdata = dest_ff ? {pr_ff, lr_ff, 1'b1, kind_ff, 5'b00000}
                                    : {12'd0, kind_ff, 5'b00000};
               if (list_tail_ff == LI_W'(LIST_DEPTH - 1)) begin
                  list_tail_in = '0;
                  lt_phase_in  = !lt_phase_ff;
               end else begin
                  list_tail_in = list_tail_ff + LI_W'(1);
               end
            end
         end
         ACT_IS_READY:    r_bit = ready_ff[pr_ff];
         ACT_CLEAR_READY: begin rdy_we = 1'b1; rdy_val = 1'b0; end
         ACT_SET_READY:   begin rdy_we = 1'b1; rdy_val = 1'b1; end
         ACT_READ:        r_data = rv_rdv_ff ? rv_rd_ff : 64'd0;
         ACT_WRITE:       rv_we = 1'b1;
         ACT_COMPLETE: begin
            info_we    = 1'b1;
            info_wdata = info_rd_ff | EI_W'(1);
         end
         ACT_SET_EXC, ACT_SET_LDVIOL, ACT_SET_BRMISP, ACT_SET_VALMISP: begin
            info_we    = 1'b1;
            info_wdata = info_rd_ff | (EI_W'(1) << (act_ff - ACT_SQUASH));
         end
         ACT_GET_EXC: r_bit = info_rd_ff[1];
         ACT_RESOLVE: begin
            if (right_ff) begin
               live_in    = live_ff & ~tag_bit;
               clr_shadow = 1'b1;
            end else begin
               live_in    = shadow_mask_ff[tag_ff] & ~tag_bit;
               seq_tag_in = tag_ff;
               if (shadow_fh_ff[tag_ff][FR_W-1:0] >= FR_W'(FREE_SIZE))
                  free_head_in = '0;
               else
                  free_head_in = shadow_fh_ff[tag_ff][FR_W-1:0];
               fh_phase_in  = shadow_fh_ff[tag_ff][FR_W];
               list_tail_in = nt;
               lt_phase_in  = (nt > list_head_ff) ? lh_phase_ff : !lh_phase_ff;
            end
         end
         ACT_PEEK_HEAD: begin
            if (!list_empty) begin
               r_hv  = 1'b1;
               r_hs  = info_rd_ff[4:0];
               r_hk  = info_rd_ff[9:5];
               r_hpc = pc_rd_ff;
            end
         end
         ACT_COMMIT: begin
            if (!head_ok) begin
               r_stall = 1'b1;
            end else begin
               if (info_rd_ff[10]) begin
                  fr_we = 1'b1;
                  cm_we = 1'b1;
                  if (free_tail_ff >= FR_W'(FREE_SIZE - 1)) begin
                     free_tail_in = '0;
                     ft_phase_in  = !ft_phase_ff;
                  end else begin
                     free_tail_in = free_tail_ff + FR_W'(1);
                  end
               end
               if (list_head_ff == LI_W'(LIST_DEPTH - 1)) begin
                  list_head_in = '0;
                  lh_phase_in  = !lh_phase_ff;
               end else begin
                  list_head_in = list_head_ff + LI_W'(1);
               end
            end
         end
         ACT_SQUASH: begin
            list_tail_in = list_head_ff;
            lt_phase_in  = 1'b0;
            lh_phase_in  = 1'b0;
            squash_cp    = 1'b1;
            live_in      = '0;
            free_head_in = free_tail_ff;
            ft_phase_in  = 1'b1;
            fh_phase_in  = 1'b0;
         end
         default: ;
      endcase
   end

   // status to controller
   assign status.need_ckpt    = (act_ff == ACT_CHECKPOINT) && slot_ok;
   assign status.need_restore = (act_ff == ACT_RESOLVE) && !right_ff;
   assign status.ckpt_last    = (seq_ff == SEQ_W'(LOG_REGS - 1));
   assign status.restore_last = (seq_ff == SEQ_W'(LOG_REGS));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0; free_tail_ff <= '0;
         fh_phase_ff  <= 1'b0; ft_phase_ff <= 1'b1;
         list_head_ff <= '0; list_tail_ff <= '0;
         lh_phase_ff  <= 1'b0; lt_phase_ff <= 1'b0;
         live_ff      <= '0;
         seq_ff       <= '0;
      end else begin
         if (cmd.exec_go) begin
            free_head_ff <= free_head_in; free_tail_ff <= free_tail_in;
            fh_phase_ff  <= fh_phase_in;  ft_phase_ff  <= ft_phase_in;
            list_head_ff <= list_head_in; list_tail_ff <= list_tail_in;
            lh_phase_ff  <= lh_phase_in;  lt_phase_ff  <= lt_phase_in;
            live_ff      <= live_in;
         end
         if (cmd.exec_go)
            seq_ff <= '0;
         else if (cmd.ckpt_step || cmd.restore_step)
            seq_ff <= seq_ff + SEQ_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_go) seq_tag_ff <= seq_tag_in;
   end

   // rename and committed maps
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOG_REGS; i++) begin
            rename_map_ff[i]    <= PR_W'(i);
            committed_map_ff[i] <= PR_W'(i);
         end
      end else begin
         if (cmd.exec_go && squash_cp) begin
            for (int i = 0; i < LOG_REGS; i++) rename_map_ff[i] <= committed_map_ff[i];
         end else if (cmd.exec_go && ren_we) begin
            rename_map_ff[lr_ff] <= fr_phys;
         end else if (cmd.restore_step && seq_ff != '0) begin
            rename_map_ff[rst_idx] <= sm_rd_ff;
         end
         if (cmd.exec_go && cm_we) committed_map_ff[cm_lr] <= info_rd_ff[22:16];
      end
   end

   // ready and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PHYS_REGS; i++) begin
            ready_ff[i]  <= (i < LOG_REGS);
            rv_vld_ff[i] <= 1'b0;
         end
         for (int i = 0; i < FREE_SIZE; i++) fr_vld_ff[i] <= 1'b0;
      end else if (cmd.exec_go) begin
         if (rdy_we) ready_ff[pr_ff] <= rdy_val;
         if (rv_we)  rv_vld_ff[pr_ff] <= 1'b1;
         if (fr_we)  fr_vld_ff[free_tail_ff] <= 1'b1;
      end
   end

   // checkpoint masks and saved free heads
   always_ff @(posedge clock) begin
      if (cmd.exec_go) begin
         if (clr_shadow) begin
            for (int i = 0; i < BR_SLOTS; i++)
               shadow_mask_ff[i] <= shadow_mask_ff[i] & ~tag_bit;
         end
         if (ckpt_we) begin
            shadow_mask_ff[slot] <= live_in;
            shadow_fh_ff[slot]   <= {fh_phase_ff, free_head_ff};
         end
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.exec_go && rv_we)   reg_mem[pr_ff] <= wv_ff;
      if (cmd.exec_go && fr_we)   free_mem[free_tail_ff] <= committed_map_ff[cm_lr];
      if (cmd.exec_go && info_we) info_mem[info_waddr] <= info_wdata;
      if (cmd.exec_go && pc_we)   pc_mem[list_tail_ff] <= pc_ff;
      if (cmd.ckpt_step)          shadow_mem[{seq_tag_ff, seq_idx}] <= rename_map_ff[seq_idx];
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.exec_go) begin
         rsp_stall_res   <= r_stall;
         rsp_phys_out    <= r_phys;
         rsp_index_out   <= r_idx;
         rsp_read_data   <= r_data;
         rsp_bit_out     <= r_bit;
         rsp_head_valid  <= r_hv;
         rsp_head_status <= r_hs;
         rsp_head_kind   <= r_hk;
         rsp_head_pc     <= r_hpc;
         rsp_branch_mask <= live_in;
      end
   end

endmodule

`default_nettype wire
